FILE: design/ed_pkg.sv
// Shared constants and types of the Euclidean divider.
package ed_pkg;

   localparam int WIDTH = 32;

   typedef logic [WIDTH-1:0] word_type;

   localparam word_type MAX_POSITIVE = {1'b0, {(WIDTH-1){1'b1}}};

   // One transaction as it moves from cell to cell along the divider chain.
   typedef struct packed {
      logic     valid;
      logic     dividend_neg;
      logic     divisor_neg;
      logic     divide_by_zero;
      word_type partial_rem;
      word_type shift_word;
      word_type divisor_mag;
   } ed_stage_type;

endpackage

FILE: design/ed_req_if.sv
// Request channel of the Euclidean divider: operands with a valid/ready handshake.
interface ed_req_if;
   import ed_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] dividend;
   logic signed [WIDTH-1:0] divisor_value;

   modport source (output valid, output dividend, output divisor_value, input ready);
   modport sink (input valid, input dividend, input divisor_value, output ready);
endinterface

FILE: design/ed_rsp_if.sv
// Response channel of the Euclidean divider: quotient, remainder and flags.
interface ed_rsp_if;
   import ed_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] quotient;
   logic signed [WIDTH-1:0] remainder;
   logic                    divide_by_zero;
   logic                    overflow;

   modport source (output valid, output quotient, output remainder,
                   output divide_by_zero, output overflow, input ready);
   modport sink (input valid, input quotient, input remainder,
                 input divide_by_zero, input overflow, output ready);
endinterface

FILE: design/euclidean_divider.sv
// Top level of the signed Euclidean divider.
// Each transaction passes through an operand stage that takes sign and magnitude, a chain
// of WIDTH restoring cells that each produce one quotient bit, and an output stage that
// applies the sign rules. The cells form a pipeline: a new request may be accepted in
// every cycle, and the whole chain holds while a response waits for ready. The remainder
// is never negative unless the divisor is zero, in which case the quotient is zero and
// the remainder returns the dividend. The most negative dividend divided by minus one
// saturates the quotient and raises overflow.
module euclidean_divider (
   input  logic     clock,
   input  logic     reset,
   ed_req_if.sink   req_chan,
   ed_rsp_if.source rsp_chan
);
   import ed_pkg::*;

   logic         advance;
   word_type     dividend_bits;
   word_type     divisor_bits;
   ed_stage_type stage0_in;
   ed_stage_type stage0_ff;
   ed_stage_type chain [0:WIDTH];

   assign req_chan.ready = advance;

   always_comb begin
      dividend_bits            = req_chan.dividend;
      divisor_bits             = req_chan.divisor_value;
      stage0_in.valid          = req_chan.valid;
      stage0_in.dividend_neg   = dividend_bits[WIDTH-1];
      stage0_in.divisor_neg    = divisor_bits[WIDTH-1];
      stage0_in.divide_by_zero = (divisor_bits == '0);
      stage0_in.partial_rem    = '0;
      stage0_in.shift_word     = dividend_bits[WIDTH-1] ? (~dividend_bits + 1'b1)
                                                        : dividend_bits;
      stage0_in.divisor_mag    = divisor_bits[WIDTH-1] ? (~divisor_bits + 1'b1)
                                                       : divisor_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff.valid <= 1'b0;
      end else if (advance) begin
         stage0_ff <= stage0_in;
      end
   end

   assign chain[0] = stage0_ff;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      ed_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .stage_i (chain[i]),
         .stage_o (chain[i+1])
      );
   end

   ed_fixup u_fixup (
      .clock    (clock),
      .reset    (reset),
      .stage_i  (chain[WIDTH]),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );
endmodule

FILE: design/ed_cell.sv
// One restoring division cell: develops one quotient bit and passes the transaction on.
module ed_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ed_pkg::ed_stage_type stage_i,
   output ed_pkg::ed_stage_type stage_o
);
   import ed_pkg::*;

   logic [WIDTH:0] shifted;
   logic [WIDTH:0] trial;
   ed_stage_type   stage_ff;
   ed_stage_type   stage_in;

   always_comb begin
      shifted  = {stage_i.partial_rem, stage_i.shift_word[WIDTH-1]};
      trial    = shifted - {1'b0, stage_i.divisor_mag};
      stage_in = stage_i;
      if (!trial[WIDTH]) begin
         stage_in.partial_rem = trial[WIDTH-1:0];
         stage_in.shift_word  = {stage_i.shift_word[WIDTH-2:0], 1'b1};
      end else begin
         stage_in.partial_rem = shifted[WIDTH-1:0];
         stage_in.shift_word  = {stage_i.shift_word[WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;
endmodule

FILE: design/ed_fixup.sv
// Output stage: applies the Euclidean sign rules and holds the response transaction.
module ed_fixup (
   input  logic                 clock,
   input  logic                 reset,
   input  ed_pkg::ed_stage_type stage_i,
   output logic                 advance,
   ed_rsp_if.source             rsp_chan
);
   import ed_pkg::*;

   word_type quot_mag;
   word_type rem_mag;
   word_type quot_inc;
   word_type quot_neg;
   word_type rem_neg;
   word_type rem_comp;
   word_type quot_pos;
   logic     rem_nonzero;
   logic     bump;
   logic     quot_is_neg;

   word_type quotient_in;
   word_type remainder_in;
   logic     divide_by_zero_in;
   logic     overflow_in;
   logic     valid_in;

   word_type quotient_ff;
   word_type remainder_ff;
   logic     divide_by_zero_ff;
   logic     overflow_ff;
   logic     valid_ff;

   assign advance = !valid_ff || rsp_chan.ready;

   always_comb begin
      quot_mag    = stage_i.shift_word;
      rem_mag     = stage_i.partial_rem;
      rem_nonzero = |rem_mag;
      bump        = stage_i.dividend_neg && rem_nonzero;
      quot_is_neg = stage_i.dividend_neg ^ stage_i.divisor_neg;
      quot_inc    = quot_mag + 1'b1;
      quot_neg    = ~quot_mag + 1'b1;
      rem_neg     = ~rem_mag + 1'b1;
      rem_comp    = stage_i.divisor_mag - rem_mag;
      quot_pos    = bump ? quot_inc : quot_mag;
   end

   always_comb begin
      valid_in          = stage_i.valid;
      divide_by_zero_in = 1'b0;
      overflow_in       = 1'b0;
      quotient_in       = '0;
      remainder_in      = bump ? rem_comp : rem_mag;
      if (stage_i.divide_by_zero) begin
         divide_by_zero_in = 1'b1;
         remainder_in      = stage_i.dividend_neg ? rem_neg : rem_mag;
      end else if (quot_is_neg) begin
         // Minus the sum of the magnitude and one is the complement of the magnitude.
         quotient_in = bump ? ~quot_mag : quot_neg;
      end else if (quot_pos[WIDTH-1]) begin
         quotient_in  = MAX_POSITIVE;
         remainder_in = '0;
         overflow_in  = 1'b1;
      end else begin
         quotient_in = quot_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff          <= valid_in;
         quotient_ff       <= quotient_in;
         remainder_ff      <= remainder_in;
         divide_by_zero_ff <= divide_by_zero_in;
         overflow_ff       <= overflow_in;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.quotient       = quotient_ff;
   assign rsp_chan.remainder      = remainder_ff;
   assign rsp_chan.divide_by_zero = divide_by_zero_ff;
   assign rsp_chan.overflow       = overflow_ff;
endmodule

FILE: design/ed_checker.sv
// Port-level checks on the Euclidean divider responses, bound to the top level.
module ed_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [ed_pkg::WIDTH-1:0] rsp_quotient,
   input logic [ed_pkg::WIDTH-1:0] rsp_remainder,
   input logic                    rsp_divide_by_zero,
   input logic                    rsp_overflow
);
   import ed_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder))
      else $error("Stalled response transaction changed.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_divide_by_zero && rsp_overflow))
      else $error("Divide by zero and overflow raised together.");

   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0)
      else $error("Quotient is not zero for a zero divisor.");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_quotient == MAX_POSITIVE && rsp_remainder == '0)
      else $error("Overflow response is not saturated.");

   a_rem_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_by_zero |-> !rsp_remainder[WIDTH-1])
      else $error("Remainder is negative.");
endmodule

bind euclidean_divider ed_checker u_ed_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_quotient       (rsp_chan.quotient),
   .rsp_remainder      (rsp_chan.remainder),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero),
   .rsp_overflow       (rsp_chan.overflow)
);
